[design/pnmrsd_pkg.sv]
// Shared constants, codes and the result record for the PNM row sample decoder.
package pnmrsd_pkg;

  // Geometry limits
  localparam int MAX_ROW_WIDTH = 4096;
  localparam int MAX_CHANNELS  = 4;

  // Field widths
  localparam int VAL_W  = 16;
  localparam int ACC_W  = 17;
  localparam int COL_W  = 12;
  localparam int CH_W   = 2;
  localparam int ERR_W  = 2;
  localparam int WID_W  = 13;
  localparam int CHN_W  = 3;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 3;

  // Plain-mode accumulator saturation point
  localparam logic [ACC_W-1:0] ACC_SAT = '1;

  // Sample modes
  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RAW1  = 2'd1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CHAR  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;
  localparam logic [ERR_W-1:0] ERR_EOD   = 2'd3;

  // Decoder phase codes
  localparam logic [1:0] PH_SKIP  = 2'd0;
  localparam logic [1:0] PH_DIGIT = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX      = 3'd1;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CHANNELS = 3'd3;

  // One result item
  typedef struct packed {
    logic [VAL_W-1:0] sample_value;
    logic [COL_W-1:0] column;
    logic [CH_W-1:0]  channel;
    logic             row_done;
    logic [ERR_W-1:0] error_code;
  } res_t;

endpackage

[design/pnm_row_sample_decoder.sv]
// PNM row sample decoder: byte stream in, one netpbm item per finished sample or error out.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one file byte per item, with
//   end_of_data marking that the file has run out. Plain mode gathers ASCII
//   decimal digits ended by whitespace; raw modes take one byte or two
//   big-endian bytes per sample. Each sample leaves on the output channel
//   (out_valid / out_stall) with its column, channel, a row_done mark and an
//   error code; errors end the row and restart the counters.
//   Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while the block is idle.
// Timing:
//   One item per cycle sustained while the receiver does not stall. A result is
//   written to the output register, or to the skid while the receiver stalls,
//   as its last byte is accepted; bytes ending no sample or error give nothing.
//   All decode work is one combinational pass from the state registers to the
//   output register; a skid register behind it absorbs one result while the
//   receiver stalls, and in_stall rises only while the skid holds an item.
// Reset (synchronous rst): mode raw one byte, max 255, width 1, channels 1,
//   decoder at column 0, channel 0, skipping whitespace, outputs empty.
module pnm_row_sample_decoder
  import pnmrsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // byte input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              end_of_data,
  // sample output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  sample_value,
  output logic [COL_W-1:0]  column,
  output logic [CH_W-1:0]   channel,
  output logic              row_done,
  output logic [ERR_W-1:0]  error_code,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [VAL_W-1:0]  cfg_data
);

  // Config registers
  logic [MODE_W-1:0] sample_mode;
  logic [VAL_W-1:0]  max_value;
  logic [WID_W-1:0]  row_width;
  logic [CHN_W-1:0]  channels;

  // Decoder state
  logic [1:0]        phase, phase_next;
  logic [ACC_W-1:0]  accumulator, accumulator_next;
  logic [7:0]        high_byte, high_byte_next;
  logic [COL_W-1:0]  column_count, column_count_next;
  logic [CH_W-1:0]   channel_count, channel_count_next;

  // Output register and skid
  res_t main_res, skid_res, res_next;
  logic main_valid, skid_valid;

  logic in_acc, out_acc, emit;
  logic [ACC_W-1:0]   emit_val;
  logic [ERR_W-1:0]   emit_err, err_final;
  logic [WID_W-1:0]   w_eff;
  logic [CHN_W-1:0]   c_eff;
  logic [WID_W-1:0]   col_inc;
  logic [CHN_W-1:0]   ch_inc;
  logic               is_digit, is_blank, last;
  logic [ACC_W+3:0]   acc_wide, acc_mul;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = main_valid && !out_stall;

  assign out_valid    = main_valid;
  assign sample_value = main_res.sample_value;
  assign column       = main_res.column;
  assign channel      = main_res.channel;
  assign row_done     = main_res.row_done;
  assign error_code   = main_res.error_code;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= MODE_RAW1;
      max_value   <= VAL_W'(255);
      row_width   <= WID_W'(1);
      channels    <= CHN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:     sample_mode <= cfg_data[MODE_W-1:0];
        REG_MAX:      max_value   <= cfg_data;
        REG_WIDTH:    row_width   <= cfg_data[WID_W-1:0];
        REG_CHANNELS: channels    <= cfg_data[CHN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry
  always_comb begin
    if (row_width == '0) begin
      w_eff = WID_W'(1);
    end else if (row_width > WID_W'(MAX_ROW_WIDTH)) begin
      w_eff = WID_W'(MAX_ROW_WIDTH);
    end else begin
      w_eff = row_width;
    end
    if (channels == '0) begin
      c_eff = CHN_W'(1);
    end else if (channels > CHN_W'(MAX_CHANNELS)) begin
      c_eff = CHN_W'(MAX_CHANNELS);
    end else begin
      c_eff = channels;
    end
  end

  // Byte classes and times-ten accumulate
  assign is_digit = (data_byte >= 8'd48) && (data_byte <= 8'd57);
  assign is_blank = (data_byte == 8'd32) || (data_byte inside {[8'd9:8'd13]});
  assign acc_wide = {4'b0, accumulator};
  assign acc_mul  = (acc_wide << 3) + (acc_wide << 1) + (ACC_W+4)'(data_byte - 8'd48);

  // Decode pass
  always_comb begin
    phase_next         = phase;
    accumulator_next   = accumulator;
    high_byte_next     = high_byte;
    column_count_next  = column_count;
    channel_count_next = channel_count;
    emit     = 1'b0;
    emit_val = '0;
    emit_err = ERR_OK;
    last     = 1'b0;
    res_next = '0;
    col_inc  = {1'b0, column_count} + WID_W'(1);
    ch_inc   = {1'b0, channel_count} + CHN_W'(1);

    if (end_of_data) begin
      emit     = 1'b1;
      emit_err = ERR_EOD;
    end else begin
      case (sample_mode)
        MODE_PLAIN: begin
          if (phase == PH_DIGIT) begin
            if (is_digit) begin
              accumulator_next = (acc_mul > (ACC_W+4)'(ACC_SAT)) ? ACC_SAT :
                                 acc_mul[ACC_W-1:0];
            end else if (is_blank) begin
              emit     = 1'b1;
              emit_val = accumulator;
            end else begin
              emit     = 1'b1;
              emit_err = ERR_CHAR;
            end
          end else begin
            if (is_blank) begin
              phase_next = PH_SKIP;
            end else if (is_digit) begin
              accumulator_next = ACC_W'(data_byte - 8'd48);
              phase_next       = PH_DIGIT;
            end else begin
              emit     = 1'b1;
              emit_err = ERR_CHAR;
            end
          end
        end
        MODE_RAW1: begin
          emit     = 1'b1;
          emit_val = ACC_W'(data_byte);
        end
        default: begin
          // two-byte raw, high byte first
          if (phase != PH_HIGH) begin
            high_byte_next = data_byte;
            phase_next     = PH_HIGH;
          end else begin
            emit     = 1'b1;
            emit_val = ACC_W'({high_byte, data_byte});
          end
        end
      endcase
    end

    // Range check and counter advance
    err_final = emit_err;
    if (emit_err == ERR_OK && emit_val > ACC_W'(max_value)) begin
      err_final = ERR_RANGE;
    end
    if (emit) begin
      res_next.column     = column_count;
      res_next.channel    = channel_count;
      res_next.error_code = err_final;
      res_next.sample_value = (err_final == ERR_OK) ? emit_val[VAL_W-1:0] : '0;
      if (err_final != ERR_OK) begin
        last = 1'b1;
      end else if (ch_inc >= c_eff) begin
        last = (col_inc >= w_eff);
        channel_count_next = '0;
        column_count_next  = col_inc[COL_W-1:0];
      end else begin
        // a column already past a shrunken row ends it
        last = ({1'b0, column_count} >= w_eff);
        channel_count_next = ch_inc[CH_W-1:0];
      end
      res_next.row_done = last;
      phase_next        = PH_SKIP;
      accumulator_next  = '0;
      if (last) begin
        high_byte_next     = '0;
        column_count_next  = '0;
        channel_count_next = '0;
      end
    end
  end

  // Decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SKIP;
      accumulator   <= '0;
      high_byte     <= '0;
      column_count  <= '0;
      channel_count <= '0;
    end else if (in_acc) begin
      phase         <= phase_next;
      accumulator   <= accumulator_next;
      high_byte     <= high_byte_next;
      column_count  <= column_count_next;
      channel_count <= channel_count_next;
    end
  end

  // Output register with one-item skid
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_acc) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_acc && emit) begin
        if (main_valid && !out_stall) begin
          main_valid <= 1'b1;
        end else if (main_valid) begin
          skid_valid <= 1'b1;
        end else begin
          main_valid <= 1'b1;
        end
      end else if (out_acc) begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_acc) begin
        main_res <= skid_res;
      end
    end else if (in_acc && emit) begin
      if (main_valid && out_stall) begin
        skid_res <= res_next;
      end else begin
        main_res <= res_next;
      end
    end
  end

  // Checks
  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid holds an item while output register is empty");

  a_err_ends_row: assert property (@(posedge clk) disable iff (rst)
    (main_valid && main_res.error_code != ERR_OK) |->
      (main_res.row_done && main_res.sample_value == '0))
    else $error("error item without row_done or with nonzero sample");

  a_skid_refills: assert property (@(posedge clk) disable iff (rst)
    (out_acc && skid_valid) |=> (main_valid && !skid_valid))
    else $error("skid item lost after output drain");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!main_valid && !skid_valid))
    else $error("output not empty after reset");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_acc && emit && last) |=> (column_count == '0 && channel_count == '0))
    else $error("counters not restarted after row end");

endmodule
